// File: design/chr_pkg.sv
// shared constants, types and tables for the cylinder hit readout segment
// used by chr_div and cylinder_hit_readout_segment; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package chr_pkg;

	localparam int CORDIC_STAGES = 18;

	// working widths
	localparam int LP_W   = 36;   // local position, Q.16
	localparam int DS_W   = 22;   // local direction parts, Q.16
	localparam int XW     = 42;   // cordic position lanes
	localparam int UW     = 37;   // cordic direction lanes
	localparam int ZW     = 35;   // cordic angle, Q.30
	localparam int RW     = 37;   // radius, Q.16
	localparam int PHI_W  = 29;   // phi, Q.24
	localparam int RPHI_W = 41;   // arc coordinate, Q.16
	localparam int NUM_W  = 54;   // divider numerator and quotient
	localparam int DEN_W  = 23;   // divider denominator
	localparam int EW     = 57;   // unsaturated output sums
	localparam int OUT_W  = 48;

	localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;
	localparam logic [31:0] PI_Q30       = 32'd3373259426;

	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
		30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
	};

	typedef enum logic [2:0] {
		REG_ROT_X,
		REG_ROT_Y,
		REG_ROT_Z,
		REG_SHIFT_X,
		REG_SHIFT_Y,
		REG_SHIFT_Z,
		REG_THICK,
		REG_DRIFT
	} chr_reg_t;

	// data riding along the cordic stages
	typedef struct packed {
		logic                   axis;
		logic signed [DS_W-1:0] ld0;
		logic signed [DS_W-1:0] ld1;
		logic signed [DS_W-1:0] ld2;
		logic signed [LP_W-1:0] lp2;
	} chr_carry_t;

	// data riding along the divider stages
	typedef struct packed {
		logic signed [RPHI_W-1:0] rphi;
		logic signed [LP_W-1:0]   axial;
		logic                     neg_a;
		logic                     neg_b;
	} chr_side_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] en_r;
		logic signed [OUT_W-1:0] en_z;
		logic signed [OUT_W-1:0] ex_r;
		logic signed [OUT_W-1:0] ex_z;
	} chr_res_t;

endpackage

`default_nettype wire

// File: design/chr_div.sv
// pipelined restoring divider: two numerators over one divisor, one quotient bit per stage
// depends on chr_pkg
`timescale 1ns / 1ps
`default_nettype none

module chr_div import chr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  logic [NUM_W-1:0] na,
	input  logic [NUM_W-1:0] nb,
	input  logic [DEN_W-1:0] d,
	input  chr_side_t        side_i,
	output logic             vld_o,
	output logic [NUM_W-1:0] qa,
	output logic [NUM_W-1:0] qb,
	output chr_side_t        side_o
);

	// element k holds the result of step k
	logic [DEN_W-1:0] ra_s [NUM_W];
	logic [DEN_W-1:0] rb_s [NUM_W];
	logic [NUM_W-1:0] qa_s [NUM_W];
	logic [NUM_W-1:0] qb_s [NUM_W];
	logic [DEN_W-1:0] d_s [NUM_W];
	chr_side_t        side_s [NUM_W];
	logic             v_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [DEN_W-1:0] ra, rb, dd;
		logic [NUM_W-1:0] qa_in, qb_in;
		chr_side_t        sd;
		logic             vv;
		logic [DEN_W:0]   ta, tb;
		logic             ga, gb;

		if (k == 0) begin : g_first
			assign ra    = '0;
			assign rb    = '0;
			assign qa_in = na;
			assign qb_in = nb;
			assign dd    = d;
			assign sd    = side_i;
			assign vv    = vld_i;
		end else begin : g_next
			assign ra    = ra_s[k-1];
			assign rb    = rb_s[k-1];
			assign qa_in = qa_s[k-1];
			assign qb_in = qb_s[k-1];
			assign dd    = d_s[k-1];
			assign sd    = side_s[k-1];
			assign vv    = v_s[k-1];
		end

		always_comb begin
			ta = {ra, qa_in[NUM_W-1]};
			tb = {rb, qb_in[NUM_W-1]};
			ga = (ta >= {1'b0, dd});
			gb = (tb >= {1'b0, dd});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[k]   <= ga ? DEN_W'(ta - {1'b0, dd}) : ta[DEN_W-1:0];
				rb_s[k]   <= gb ? DEN_W'(tb - {1'b0, dd}) : tb[DEN_W-1:0];
				qa_s[k]   <= {qa_in[NUM_W-2:0], ga};
				qb_s[k]   <= {qb_in[NUM_W-2:0], gb};
				d_s[k]    <= dd;
				side_s[k] <= sd;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vv;
			end
		end
	end

	assign vld_o  = v_s[NUM_W-1];
	assign qa     = qa_s[NUM_W-1];
	assign qb     = qb_s[NUM_W-1];
	assign side_o = side_s[NUM_W-1];

endmodule

`default_nettype wire

// File: design/cylinder_hit_readout_segment.sv
// cylinder hit readout segment: hit to entry/exit points on a cylindrical sensor
// depends on chr_pkg and chr_div
//
//   channel  | direction | handshake              | payload
//   hit      | in        | hit_valid, hit_stall   | hit_x/y/z, dir_x/y/z
//   seg      | out       | seg_valid, seg_stall   | entry_rphi/axial, exit_rphi/axial
//   config   | in        | apb psel/penable/...   | 64 bit data, register i at 8*i
//
// one hit per cycle while the skid register is empty; the pipeline length is set by the
// 18 cordic stages and the 54 stage divider for the half segment
// the whole pipeline advances together unless a result sits in the skid register
// hit_stall comes straight from that register, so a result waiting on seg_stall
// does not block the next request while the skid is empty
// reset clears valid bits and loads the default configuration; the drift divider runs freely on
// the configuration and settles well before a request reaches it
`timescale 1ns / 1ps
`default_nettype none

module cylinder_hit_readout_segment import chr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// hit channel
	input  logic                    hit_valid,
	output logic                    hit_stall,
	input  logic signed [31:0]      hit_x,
	input  logic signed [31:0]      hit_y,
	input  logic signed [31:0]      hit_z,
	input  logic signed [17:0]      dir_x,
	input  logic signed [17:0]      dir_y,
	input  logic signed [17:0]      dir_z,
	// segment channel
	output logic                    seg_valid,
	input  logic                    seg_stall,
	output logic signed [OUT_W-1:0] entry_rphi,
	output logic signed [OUT_W-1:0] entry_axial,
	output logic signed [OUT_W-1:0] exit_rphi,
	output logic signed [OUT_W-1:0] exit_axial,
	// configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [5:0]              paddr,
	input  logic [63:0]             pwdata,
	output logic [63:0]             prdata,
	output logic                    pready
);

	localparam int PP_W = 50;
	localparam int DP_W = 36;
	localparam int AP_W = 52;
	localparam int AD_W = 38;
	localparam int PX_W = XW + 25;
	localparam int PU_W = UW + 25;
	localparam int RP_W = RW + PHI_W;
	localparam int DT_W = 50;

	localparam logic signed [AP_W-1:0] RND_AP = AP_W'(1) <<< 15;
	localparam logic signed [AD_W-1:0] RND_AD = AD_W'(1) <<< 15;
	localparam logic signed [PX_W-1:0] RND_PX = PX_W'(1) <<< 27;
	localparam logic signed [PU_W-1:0] RND_PU = PU_W'(1) <<< 37;
	localparam logic signed [ZW-1:0]   RND_Z  = ZW'(32);
	localparam logic signed [RP_W-1:0] RND_RP = RP_W'(1) <<< 23;
	localparam logic [DEN_W-1:0]       DEN_TANGENT = DEN_W'(131072);
	localparam logic [DEN_W-1:0]       DD_NONE     = DEN_W'(65536);

	// ---------------- configuration ----------------
	logic [53:0]        rot_q [3];
	logic signed [31:0] shift_q [3];
	logic [30:0]        thick_q;
	logic [53:0]        drift_q;
	chr_reg_t           reg_idx;

	assign reg_idx = chr_reg_t'(paddr[5:3]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0]   <= 54'd65536;
			rot_q[1]   <= 54'd65536 << 18;
			rot_q[2]   <= 54'd65536 << 36;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
			thick_q    <= 31'd19661;
			drift_q    <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_ROT_X:   rot_q[0]   <= pwdata[53:0];
				REG_ROT_Y:   rot_q[1]   <= pwdata[53:0];
				REG_ROT_Z:   rot_q[2]   <= pwdata[53:0];
				REG_SHIFT_X: shift_q[0] <= pwdata[31:0];
				REG_SHIFT_Y: shift_q[1] <= pwdata[31:0];
				REG_SHIFT_Z: shift_q[2] <= pwdata[31:0];
				REG_THICK:   thick_q    <= pwdata[30:0];
				REG_DRIFT:   drift_q    <= pwdata[53:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROT_X:   prdata = {10'd0, rot_q[0]};
			REG_ROT_Y:   prdata = {10'd0, rot_q[1]};
			REG_ROT_Z:   prdata = {10'd0, rot_q[2]};
			REG_SHIFT_X: prdata = {32'd0, shift_q[0]};
			REG_SHIFT_Y: prdata = {32'd0, shift_q[1]};
			REG_SHIFT_Z: prdata = {32'd0, shift_q[2]};
			REG_THICK:   prdata = {33'd0, thick_q};
			REG_DRIFT:   prdata = {10'd0, drift_q};
			default:     prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	logic adv;
	logic skid_v_q, out_v_q;

	assign adv       = !skid_v_q;
	assign hit_stall = skid_v_q;

	// ---------------- s1: rotation products ----------------
	logic signed [31:0]      hp [3];
	logic signed [17:0]      hd [3];
	logic signed [PP_W-1:0]  pp_s1 [3][3];
	logic signed [DP_W-1:0]  dp_s1 [3][3];
	logic                    v_s1;

	assign hp[0] = hit_x;
	assign hp[1] = hit_y;
	assign hp[2] = hit_z;
	assign hd[0] = dir_x;
	assign hd[1] = dir_y;
	assign hd[2] = dir_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					pp_s1[j][k] <= $signed(rot_q[j][18*k +: 18]) * hp[k];
					dp_s1[j][k] <= $signed(rot_q[j][18*k +: 18]) * hd[k];
				end
			end
		end
	end

	// ---------------- s2: local position and direction ----------------
	logic signed [AP_W-1:0] ap [3];
	logic signed [AD_W-1:0] ad [3];
	logic signed [LP_W-1:0] lp_s2 [3];
	logic signed [DS_W-1:0] ld_s2 [3];
	logic                   v_s2;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ap[j] = $signed({{(AP_W-48){shift_q[j][31]}}, shift_q[j], 16'd0})
				+ AP_W'(pp_s1[j][0]) + AP_W'(pp_s1[j][1]) + AP_W'(pp_s1[j][2])
				+ RND_AP;
			ad[j] = AD_W'(dp_s1[j][0]) + AD_W'(dp_s1[j][1]) + AD_W'(dp_s1[j][2])
				+ RND_AD;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				lp_s2[j] <= ap[j][AP_W-1:16];
				ld_s2[j] <= ad[j][DS_W+15:16];
			end
		end
	end

	// ---------------- s3 and cordic stages ----------------
	logic signed [XW-1:0] cx_s [CORDIC_STAGES+1];
	logic signed [XW-1:0] cy_s [CORDIC_STAGES+1];
	logic signed [UW-1:0] cu_s [CORDIC_STAGES+1];
	logic signed [UW-1:0] cv_s [CORDIC_STAGES+1];
	logic signed [ZW-1:0] cz_s [CORDIC_STAGES+1];
	chr_carry_t           cc_s [CORDIC_STAGES+1];
	logic                 cval_s [CORDIC_STAGES+1];

	logic signed [XW-1:0] x0, y0;
	logic signed [UW-1:0] u0, v0;
	logic signed [ZW-1:0] pi_z;

	always_comb begin
		x0   = $signed({{(XW-LP_W-4){lp_s2[0][LP_W-1]}}, lp_s2[0], 4'd0});
		y0   = $signed({{(XW-LP_W-4){lp_s2[1][LP_W-1]}}, lp_s2[1], 4'd0});
		u0   = $signed({{(UW-DS_W-14){ld_s2[0][DS_W-1]}}, ld_s2[0], 14'd0});
		v0   = $signed({{(UW-DS_W-14){ld_s2[1][DS_W-1]}}, ld_s2[1], 14'd0});
		pi_z = $signed({{(ZW-32){1'b0}}, PI_Q30});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// left half-plane: turn by pi first
			if (lp_s2[0][LP_W-1]) begin
				cx_s[0] <= -x0;
				cy_s[0] <= -y0;
				cu_s[0] <= -u0;
				cv_s[0] <= -v0;
				cz_s[0] <= lp_s2[1][LP_W-1] ? -pi_z : pi_z;
			end else begin
				cx_s[0] <= x0;
				cy_s[0] <= y0;
				cu_s[0] <= u0;
				cv_s[0] <= v0;
				cz_s[0] <= '0;
			end
			cc_s[0].axis <= (lp_s2[0] == '0) && (lp_s2[1] == '0);
			cc_s[0].ld0  <= ld_s2[0];
			cc_s[0].ld1  <= ld_s2[1];
			cc_s[0].ld2  <= ld_s2[2];
			cc_s[0].lp2  <= lp_s2[2];
		end
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		logic signed [XW-1:0] xs, ys;
		logic signed [UW-1:0] us, vs;
		logic signed [ZW-1:0] az;

		assign xs = cx_s[k] >>> k;
		assign ys = cy_s[k] >>> k;
		assign us = cu_s[k] >>> k;
		assign vs = cv_s[k] >>> k;
		assign az = $signed({{(ZW-30){1'b0}}, ATAN_Q30[k]});

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cy_s[k][XW-1]) begin
					cx_s[k+1] <= cx_s[k] + ys;
					cy_s[k+1] <= cy_s[k] - xs;
					cu_s[k+1] <= cu_s[k] + vs;
					cv_s[k+1] <= cv_s[k] - us;
					cz_s[k+1] <= cz_s[k] + az;
				end else begin
					cx_s[k+1] <= cx_s[k] - ys;
					cy_s[k+1] <= cy_s[k] + xs;
					cu_s[k+1] <= cu_s[k] - vs;
					cv_s[k+1] <= cv_s[k] + us;
					cz_s[k+1] <= cz_s[k] - az;
				end
				cc_s[k+1] <= cc_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cval_s[k+1] <= 1'b0;
			end else if (adv) begin
				cval_s[k+1] <= cval_s[k];
			end
		end
	end

	// ---------------- s4: gain products ----------------
	logic signed [PX_W-1:0]  px_s4;
	logic signed [PU_W-1:0]  pu_s4, pv_s4;
	logic signed [PHI_W-1:0] phi_s4;
	chr_carry_t              cc_s4;
	logic signed [ZW-1:0]    zr;
	logic                    v_s4;

	assign zr = cz_s[CORDIC_STAGES] + RND_Z;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s4  <= cx_s[CORDIC_STAGES] * $signed({1'b0, INV_GAIN_Q24});
			pu_s4  <= cu_s[CORDIC_STAGES] * $signed({1'b0, INV_GAIN_Q24});
			pv_s4  <= cv_s[CORDIC_STAGES] * $signed({1'b0, INV_GAIN_Q24});
			phi_s4 <= zr[ZW-1:6];
			cc_s4  <= cc_s[CORDIC_STAGES];
		end
	end

	// ---------------- s5: radius, phi, direction parts ----------------
	logic signed [PX_W-1:0]  rx;
	logic signed [PU_W-1:0]  ru, rv;
	logic signed [RW-1:0]    r_s5;
	logic signed [PHI_W-1:0] phi_s5;
	logic signed [DS_W-1:0]  dsr_s5, dst_s5, ld2_s5;
	logic signed [LP_W-1:0]  lp2_s5;
	logic                    v_s5;

	assign rx = px_s4 + RND_PX;
	assign ru = pu_s4 + RND_PU;
	assign rv = pv_s4 + RND_PU;

	always_ff @(posedge clk) begin
		if (adv) begin
			// hit on the axis: no angle, direction x/y taken as they are
			if (cc_s4.axis) begin
				r_s5   <= '0;
				phi_s5 <= '0;
				dsr_s5 <= cc_s4.ld0;
				dst_s5 <= cc_s4.ld1;
			end else begin
				r_s5   <= rx[RW+27:28];
				phi_s5 <= phi_s4;
				dsr_s5 <= ru[DS_W+37:38];
				dst_s5 <= rv[DS_W+37:38];
			end
			ld2_s5 <= cc_s4.ld2;
			lp2_s5 <= cc_s4.lp2;
		end
	end

	// ---------------- s6: arc product, half segment numerators ----------------
	logic signed [RP_W-1:0]  rp_s6;
	logic signed [NUM_W-1:0] nt_s6, nz_s6;
	logic [DEN_W-1:0]        den_s6;
	logic signed [LP_W-1:0]  lp2_s6;
	logic [DEN_W-1:0]        ar;
	logic                    v_s6;

	assign ar = dsr_s5[DS_W-1] ? DEN_W'(-dsr_s5) : DEN_W'(dsr_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			rp_s6  <= r_s5 * phi_s5;
			nt_s6  <= dst_s5 * $signed({1'b0, thick_q});
			nz_s6  <= ld2_s5 * $signed({1'b0, thick_q});
			// tangent track: the thickness itself is the scale
			den_s6 <= (ar == '0) ? DEN_TANGENT : {ar[DEN_W-2:0], 1'b0};
			lp2_s6 <= lp2_s5;
		end
	end

	// ---------------- s7: divider operands ----------------
	logic signed [RP_W-1:0] rrp;
	logic [NUM_W-1:0]       nt_abs, nz_abs;
	logic [NUM_W-1:0]       na_s7, nb_s7;
	logic [DEN_W-1:0]       den_s7;
	chr_side_t              side_s7;
	logic                   v_s7;

	always_comb begin
		rrp    = rp_s6 + RND_RP;
		nt_abs = nt_s6[NUM_W-1] ? NUM_W'(-nt_s6) : NUM_W'(nt_s6);
		nz_abs = nz_s6[NUM_W-1] ? NUM_W'(-nz_s6) : NUM_W'(nz_s6);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			na_s7         <= nt_abs + NUM_W'(den_s6 >> 1);
			nb_s7         <= nz_abs + NUM_W'(den_s6 >> 1);
			den_s7        <= den_s6;
			side_s7.rphi  <= rrp[RPHI_W+23:24];
			side_s7.axial <= lp2_s6;
			side_s7.neg_a <= nt_s6[NUM_W-1];
			side_s7.neg_b <= nz_s6[NUM_W-1];
		end
	end

	// ---------------- half segment divider ----------------
	logic             dv_o;
	logic [NUM_W-1:0] hq_t, hq_z;
	chr_side_t        dside;

	chr_div u_half_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (v_s7),
		.na     (na_s7),
		.nb     (nb_s7),
		.d      (den_s7),
		.side_i (side_s7),
		.vld_o  (dv_o),
		.qa     (hq_t),
		.qb     (hq_z),
		.side_o (dside)
	);

	// ---------------- drift shift, from configuration only ----------------
	logic signed [17:0]      dt, da, dr;
	logic [DEN_W-1:0]        dd;
	logic signed [DT_W-1:0]  dtt, dat;
	logic [NUM_W-1:0]        nd_t_q, nd_a_q;
	logic [DEN_W-1:0]        dd_q;
	logic [NUM_W-1:0]        sq_t, sq_a;
	logic                    drift_on, drift_en, drift_ex;
	chr_side_t               side_none;

	always_comb begin
		dt        = $signed(drift_q[17:0]);
		da        = $signed(drift_q[35:18]);
		dr        = $signed(drift_q[53:36]);
		dd        = (dr == '0) ? DD_NONE : (dr[17] ? DEN_W'(-dr) : DEN_W'(dr));
		dtt       = dt * $signed({1'b0, thick_q});
		dat       = da * $signed({1'b0, thick_q});
		drift_on  = (dt != '0) || (da != '0);
		drift_en  = drift_on && !dr[17] && (dr != '0);
		drift_ex  = drift_on && dr[17];
		side_none = '0;
	end

	always_ff @(posedge clk) begin
		nd_t_q <= (dtt[DT_W-1] ? NUM_W'(-dtt) : NUM_W'(dtt)) + NUM_W'(dd >> 1);
		nd_a_q <= (dat[DT_W-1] ? NUM_W'(-dat) : NUM_W'(dat)) + NUM_W'(dd >> 1);
		dd_q   <= dd;
	end

	chr_div u_drift_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (1'b1),
		.vld_i  (1'b0),
		.na     (nd_t_q),
		.nb     (nd_a_q),
		.d      (dd_q),
		.side_i (side_none),
		.vld_o  (),
		.qa     (sq_t),
		.qb     (sq_a),
		.side_o ()
	);

	// ---------------- s8: entry and exit sums ----------------
	logic signed [EW-1:0] hr, hz, st, sa, rphi_e, ax_e;
	logic signed [EW-1:0] enr_s8, enz_s8, exr_s8, exz_s8;
	logic                 v_s8;

	always_comb begin
		hr     = $signed({{(EW-NUM_W){1'b0}}, hq_t});
		hz     = $signed({{(EW-NUM_W){1'b0}}, hq_z});
		st     = $signed({{(EW-NUM_W){1'b0}}, sq_t});
		sa     = $signed({{(EW-NUM_W){1'b0}}, sq_a});
		hr     = dside.neg_a ? -hr : hr;
		hz     = dside.neg_b ? -hz : hz;
		st     = dt[17] ? -st : st;
		sa     = da[17] ? -sa : sa;
		rphi_e = EW'(dside.rphi);
		ax_e   = EW'(dside.axial);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			enr_s8 <= rphi_e - hr + (drift_en ? st : '0);
			enz_s8 <= ax_e - hz + (drift_en ? sa : '0);
			exr_s8 <= rphi_e + hr + (drift_ex ? st : '0);
			exz_s8 <= ax_e + hz + (drift_ex ? sa : '0);
		end
	end

	// ---------------- s9: saturation ----------------
	function automatic logic signed [OUT_W-1:0] sat48(input logic signed [EW-1:0] v);
		logic [EW-OUT_W:0] top;
		top = v[EW-1:OUT_W-1];
		if ((top == '0) || (top == '1)) begin
			return v[OUT_W-1:0];
		end
		return v[EW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
	endfunction

	chr_res_t res_s9;
	logic     v_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s9.en_r <= sat48(enr_s8);
			res_s9.en_z <= sat48(enz_s8);
			res_s9.ex_r <= sat48(exr_s8);
			res_s9.ex_z <= sat48(exz_s8);
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			cval_s[0] <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
		end else if (adv) begin
			v_s1      <= hit_valid;
			v_s2      <= v_s1;
			cval_s[0] <= v_s2;
			v_s4      <= cval_s[CORDIC_STAGES];
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= dv_o;
			v_s9      <= v_s8;
		end
	end

	// ---------------- output register and skid ----------------
	chr_res_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (!out_v_q || !seg_stall) begin
				out_v_q <= v_s9;
			end else if (v_s9) begin
				skid_v_q <= 1'b1;
			end
		end else if (!seg_stall) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (!out_v_q || !seg_stall) begin
				out_q <= res_s9;
			end else begin
				skid_q <= res_s9;
			end
		end else if (!seg_stall) begin
			out_q <= skid_q;
		end
	end

	assign seg_valid   = out_v_q;
	assign entry_rphi  = out_q.en_r;
	assign entry_axial = out_q.en_z;
	assign exit_rphi   = out_q.ex_r;
	assign exit_axial  = out_q.ex_z;

endmodule

`default_nettype wire
